FILE: src/ftm_pkg.sv
`default_nettype none
package ftm_pkg;

  localparam int IN_W      = 16;
  localparam int Q_W       = 16;
  localparam int SQ_W      = 32;
  localparam int NUM_W     = 37;
  localparam int DEN_W     = 36;
  localparam int SPLIT_W   = 19;
  localparam int SCALE_W   = 29;
  localparam int DIV_W     = 50;
  localparam int REM_W     = 67;
  localparam int CHANNEL_BITS_DEF = 16;

  localparam logic [SCALE_W-1:0] SCALE_N = SCALE_W'(501268480);
  localparam logic [14:0]        DIV_K   = 15'd16639;
  localparam logic [4:0]         NUM_SQ_K  = 5'd21;
  localparam logic [8:0]         NUM_LIN_K = 9'd320;
  localparam logic [3:0]         DEN_SQ_K  = 4'd15;
  localparam logic [12:0]        DEN_LIN_K = 13'd6400;
  localparam logic [16:0]        DEN_OFS   = 17'd98304;

endpackage
`default_nettype wire

FILE: src/ftm_div_cell.sv
`default_nettype none
module ftm_div_cell
  import ftm_pkg::*;
#(
  parameter int BIT = 0
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [REM_W-1:0] rem_i,
  input  wire logic [DIV_W-1:0] div_i,
  input  wire logic [Q_W-1:0]   q_i,
  output logic      [REM_W-1:0] rem_o,
  output logic      [DIV_W-1:0] div_o,
  output logic      [Q_W-1:0]   q_o
);

  logic [REM_W-1:0] rem_r, rem_nxt, shifted;
  logic [DIV_W-1:0] div_r;
  logic [Q_W-1:0]   q_r, q_nxt;

  always_comb begin
    shifted = REM_W'(div_i) << BIT;
    rem_nxt = rem_i;
    q_nxt   = q_i;
    if (rem_i >= shifted) begin
      rem_nxt = rem_i - shifted;
      q_nxt[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      div_r <= div_i;
      q_r   <= q_nxt;
    end
  end

  assign rem_o = rem_r;
  assign div_o = div_r;
  assign q_o   = q_r;

endmodule
`default_nettype wire

FILE: src/ftm_channel.sv
`default_nettype none
module ftm_channel
  import ftm_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [CHANNEL_BITS-1:0] code_i,
  output logic      [CHANNEL_BITS-1:0] code_o
);

  localparam logic [32:0] OUT_MAX = (CHANNEL_BITS < 16) ?
                                    33'((64'd1 << CHANNEL_BITS) - 64'd1) : 33'd65535;

  logic [IN_W-1:0] n_w, n_r;
  logic [SQ_W-1:0] sq_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [47:0] plo_r;
  logic [46:0] phi_r;
  logic [DIV_W-1:0] m3_r, m4_r;
  logic [REM_W-1:0] d_r;
  logic [CHANNEL_BITS-1:0] out_r, out_nxt;

  generate
    if (CHANNEL_BITS < IN_W) begin : g_narrow
      assign n_w = IN_W'(code_i);
    end else begin : g_wide
      assign n_w = code_i[IN_W-1:0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      n_r   <= n_w;
      sq_r  <= SQ_W'(n_w) * SQ_W'(n_w);
      num_r <= NUM_W'(sq_r) * NUM_W'(NUM_SQ_K) + NUM_W'(n_r) * NUM_W'(NUM_LIN_K);
      den_r <= DEN_W'(sq_r) * DEN_W'(DEN_SQ_K) + DEN_W'(n_r) * DEN_W'(DEN_LIN_K)
               + DEN_W'(DEN_OFS);
      plo_r <= 48'(num_r[SPLIT_W-1:0]) * 48'(SCALE_N);
      phi_r <= 47'(num_r[NUM_W-1:SPLIT_W]) * 47'(SCALE_N);
      m3_r  <= DIV_W'(den_r) * DIV_W'(DIV_K);
      d_r   <= (REM_W'(phi_r) << SPLIT_W) + REM_W'(plo_r) + REM_W'(m3_r >> 1);
      m4_r  <= m3_r;
      out_r <= out_nxt;
    end
  end

  logic [REM_W-1:0] rem_c [Q_W+1];
  logic [DIV_W-1:0] div_c [Q_W+1];
  logic [Q_W-1:0]   q_c   [Q_W+1];

  assign rem_c[0] = d_r;
  assign div_c[0] = m4_r;
  assign q_c[0]   = '0;

  generate
    for (genvar i = 0; i < Q_W; i++) begin : g_cell
      ftm_div_cell #(.BIT(Q_W-1-i)) u_cell (
        .clk   (clk),
        .en    (en),
        .rem_i (rem_c[i]),
        .div_i (div_c[i]),
        .q_i   (q_c[i]),
        .rem_o (rem_c[i+1]),
        .div_o (div_c[i+1]),
        .q_o   (q_c[i+1])
      );
    end
  endgenerate

  logic [32:0] q_ext;
  always_comb begin
    q_ext = 33'(q_c[Q_W]);
    if (q_ext > OUT_MAX) q_ext = OUT_MAX;
    out_nxt = CHANNEL_BITS'(q_ext);
  end

  assign code_o = out_r;

endmodule
`default_nettype wire

FILE: src/filmic_tone_map_top.sv
// Filmic tone mapper: one HDR RGB pixel in, one tone-mapped RGB pixel out.
// Input channel: in_valid, in_stall and the unsigned Q8.8 fields in_red,
// in_green and in_blue. Output channel: out_valid, out_stall and the
// unsigned Q1.15 fields out_red, out_green and out_blue, saturating.
// A transfer takes place on a rising edge with valid high and stall low.
// From input transfer to out_valid, a pixel passes four arithmetic
// stages, sixteen divider cells (one quotient bit each) and an output
// register. Throughput is one pixel per cycle unless out_stall holds the
// pipeline, set by the divider chain whose cells pass remainders each cycle.
// The whole pipeline holds while a result waits under out_stall; in_stall
// is raised exactly then. Reset empties the pipeline and clears out_valid.
`default_nettype none
module filmic_tone_map_top
  import ftm_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [CHANNEL_BITS-1:0] in_red,
  input  wire logic [CHANNEL_BITS-1:0] in_green,
  input  wire logic [CHANNEL_BITS-1:0] in_blue,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic      [CHANNEL_BITS-1:0] out_red,
  output logic      [CHANNEL_BITS-1:0] out_green,
  output logic      [CHANNEL_BITS-1:0] out_blue
);

  localparam int LAT = 4 + Q_W + 1;

  logic [LAT-1:0] valid_r, valid_nxt;
  logic en;

  assign en       = !(valid_r[LAT-1] && out_stall);
  assign in_stall = !en;
  assign valid_nxt = en ? {valid_r[LAT-2:0], in_valid} : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign out_valid = valid_r[LAT-1];

  ftm_channel #(.CHANNEL_BITS(CHANNEL_BITS)) u_red (
    .clk(clk), .en(en), .code_i(in_red), .code_o(out_red)
  );
  ftm_channel #(.CHANNEL_BITS(CHANNEL_BITS)) u_green (
    .clk(clk), .en(en), .code_i(in_green), .code_o(out_green)
  );
  ftm_channel #(.CHANNEL_BITS(CHANNEL_BITS)) u_blue (
    .clk(clk), .en(en), .code_i(in_blue), .code_o(out_blue)
  );

endmodule
`default_nettype wire

FILE: bench/tb.sv
`default_nettype none
module tb;
  import ftm_pkg::*;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] red_in = '0;
  logic [15:0] green_in = '0;
  logic [15:0] blue_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] red_out;
  logic [15:0] green_out;
  logic [15:0] blue_out;

  pixel_t      pending_pixels[$];
  pixel_t      expected_pixels[$];
  int          n_failures = 0;
  int          n_sent = 0;
  int          n_mapped = 0;
  int          n_cycles = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  bit          calm = 1'b0;

  filmic_tone_map_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_red(red_in), .in_green(green_in), .in_blue(blue_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red(red_out), .out_green(green_out), .out_blue(blue_out)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] tone_curve(logic [15:0] code);
    logic [63:0] n, num, den, m, u, uq, ur, res;
    n = 64'(code);
    num = 21 * n * n + 320 * n;
    den = 15 * n * n + 6400 * n + 98304;
    m = 64'd16639 * den;
    u = num * 64'd81920;
    uq = u / m;
    ur = u % m;
    res = uq * 64'd6119 + (ur * 64'd6119 + m / 2) / m;
    if (res > 64'hFFFF) res = 64'hFFFF;
    return res[15:0];
  endfunction

  function automatic logic [15:0] random_code();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 255));
      1: return 16'($urandom_range(0, 4095));
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_pixels.push_back('{tone_curve(red_in), tone_curve(green_in),
                                    tone_curve(blue_in)});
        n_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_pixels.size() > 0 && (calm || $urandom_range(0, 99) >= 22)) begin
          pixel_t p;
          p = pending_pixels.pop_front();
          in_valid <= 1'b1;
          red_in <= p.red;
          green_in <= p.green;
          blue_in <= p.blue;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("result transfer with no pixel outstanding");
        n_failures++;
      end else begin
        pixel_t e;
        e = expected_pixels.pop_front();
        if (red_out !== e.red) begin
          $error("red_out expected %0d actual %0d", e.red, red_out);
          n_failures++;
        end
        if (green_out !== e.green) begin
          $error("green_out expected %0d actual %0d", e.green, green_out);
          n_failures++;
        end
        if (blue_out !== e.blue) begin
          $error("blue_out expected %0d actual %0d", e.blue, blue_out);
          n_failures++;
        end
        n_mapped++;
      end
    end
  end

  // Receiver stall, with one long hold-off once more than 600 pixels have been sent.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && n_sent > 600) begin
      hold_done <= 1'b1;
      hold_left <= 200;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && $urandom_range(0, 99) < 22;
    end
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    calm <= (n_sent > 900 && n_sent < 1200);
    if (n_cycles > 200000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [15:0] corner[8];
    corner = '{16'h0000, 16'h0001, 16'h00FF, 16'h0100,
               16'h0B33, 16'h7FFF, 16'h8000, 16'hFFFF};
    for (int i = 0; i < 8; i++)
      pending_pixels.push_back('{corner[i], corner[7 - i], corner[(i + 3) % 8]});
    for (int b = 0; b < 16; b++)
      pending_pixels.push_back('{16'(1 << b), ~16'(1 << b), 16'(1 << b)});
    for (int i = 0; i < 1700; i++)
      pending_pixels.push_back('{random_code(), random_code(), random_code()});
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_pixels.size() == 0 && !in_valid);
    @(posedge clk);
    wait (expected_pixels.size() == 0);
    repeat (30) @(posedge clk);
    $display("Mapped %0d pixels, covering channel extremes, every input bit,", n_mapped);
    $display("random idling on both sides and one long output hold-off.");
    if (n_failures == 0 && expected_pixels.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
